// ----- hdl/dsc_pkg.sv -----
// Shared types and constants of the divisible subarray counter.
package dsc_pkg;

    localparam int VALUE_W    = 32;  // input value field
    localparam int CFG_W      = 17;  // modulus register
    localparam int TOTAL_W    = 64;  // running total of divisible runs
    localparam int RES_OUT_W  = 16;  // residue as reported on the result
    localparam int COUNT_W    = 32;  // histogram entry count
    localparam int TAG_W      = 8;   // sequence epoch stored with each entry

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } t_hist_word;

endpackage

// ----- hdl/dsc_if.sv -----
// Valid/ready channel interfaces for items, results and configuration.
interface dsc_item_if;
    import dsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               first;
    modport source (output valid, output value, output first, input ready);
    modport sink (input valid, input value, input first, output ready);
endinterface

interface dsc_result_if;
    import dsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TOTAL_W-1:0]   total_runs;
    logic [RES_OUT_W-1:0] prefix_residue;
    modport source (output valid, output total_runs, output prefix_residue, input ready);
    modport sink (input valid, input total_runs, input prefix_residue, output ready);
endinterface

interface dsc_cfg_if;
    import dsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] modulus;
    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

// ----- hdl/dsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dsc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/dsc_divider.sv -----
// Restoring remainder unit: one dividend bit per cycle.
module dsc_divider #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    // The remainder stays below the divisor, so one more bit holds the shifted value.
    always_comb begin
        shifted = {r_rem, r_dvd[DVD_W-1]};
        trial   = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= trial[DVS_W] ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hdl/divisible_subarray_counter.sv -----
// Top level: counts contiguous runs whose sum is divisible by the modulus.
//
// Channels: i_item carries one value and a first flag per transaction,
// o_result returns one transaction per item with the running count of
// divisible runs and the prefix residue. i_cfg writes the modulus
// (reset 1, zero acts as 1, values above MAX_MODULUS act as MAX_MODULUS);
// it is always ready, and the user must write it only while no item
// is in flight: the block itself does not enforce this. Each item is
// accepted, reduced in the single restoring remainder unit over SUM_W
// dividend bits (SUM_W is one more than the wider of the value and
// residue widths, 33 with the defaults), then its histogram entry is
// read and updated by read-modify-write, and the output register is
// loaded. The block takes one item at a time; i_item.ready is high
// only in idle.
// The histogram lives in one RAM of MAX_MODULUS entries tagged with an
// 8-bit sequence epoch, so a first flag clears it in no time. After reset,
// and on every 255th first flag, a clearing pass over all MAX_MODULUS
// entries runs before the item proceeds. A stalled receiver holds the
// result in the output register; the next item is accepted meanwhile
// and waits for the register to empty before its result is loaded.
module divisible_subarray_counter #(
    parameter int MAX_MODULUS = 65536,
    parameter int VALUE_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dsc_item_if.sink     i_item,
    dsc_result_if.source o_result,
    dsc_cfg_if.sink      i_cfg
);
    import dsc_pkg::*;

    localparam int AW     = $clog2(MAX_MODULUS);
    localparam int MOD_W  = $clog2(MAX_MODULUS + 1);
    localparam int USED_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int SUM_W  = ((USED_W > AW) ? USED_W : AW) + 1;
    localparam int HW     = TAG_W + COUNT_W;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_modulus;
    logic [MOD_W-1:0]     mod_eff;
    logic [AW-1:0]        r_residue;
    logic [TOTAL_W-1:0]   r_total;
    logic [TAG_W-1:0]     r_epoch;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_clr_item;
    logic [AW-1:0]        r_res;
    logic                 r_out_valid;
    logic [TOTAL_W-1:0]   r_out_total;
    logic [RES_OUT_W-1:0] r_out_res;

    logic                 accept;
    logic                 div_start;
    logic [SUM_W-1:0]     dividend;
    logic                 div_done;
    logic [MOD_W-1:0]     div_rem;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_hist_word           ram_wdata;
    t_hist_word           ram_rdata;
    logic [COUNT_W-1:0]   hit_count;
    logic [TOTAL_W:0]     total_sum;
    logic [TOTAL_W-1:0]   total_next;
    logic                 out_free;
    logic                 clr_last;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;
    assign clr_last     = (r_clr_addr == AW'(MAX_MODULUS - 1));

    always_comb begin
        if (r_modulus == '0) begin
            mod_eff = MOD_W'(1);
        end else if (32'(r_modulus) > 32'(MAX_MODULUS)) begin
            mod_eff = MOD_W'(MAX_MODULUS);
        end else begin
            mod_eff = MOD_W'(r_modulus);
        end
    end

    // A new sequence starts from residue zero; the old residue is reduced
    // together with the value, which gives the same residue.
    assign dividend = SUM_W'(i_item.first ? '0 : r_residue)
                    + SUM_W'(i_item.value[USED_W-1:0]);
    assign div_start = accept;

    dsc_divider #(
        .DVD_W(SUM_W),
        .DVS_W(MOD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (mod_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // An entry written in an older sequence reads as zero.
    assign hit_count  = (ram_rdata.tag == r_epoch) ? ram_rdata.count : '0;
    assign total_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(hit_count)
                      + (TOTAL_W + 1)'(r_res == '0);
    assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

    always_comb begin
        n_state         = r_state;
        ram_we          = 1'b0;
        ram_waddr       = r_res;
        ram_wdata.tag   = r_epoch;
        ram_wdata.count = (hit_count == '1) ? hit_count : hit_count + 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we          = 1'b1;
                ram_waddr       = r_clr_addr;
                ram_wdata.tag   = '0;
                ram_wdata.count = '0;
                if (clr_last) begin
                    n_state = r_clr_item ? ST_DIV : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.first && r_epoch == '1) ? ST_CLEAR : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ram_we  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    dsc_ram #(
        .WIDTH(HW),
        .DEPTH(MAX_MODULUS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (div_rem[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_modulus   <= CFG_W'(1);
            r_residue   <= '0;
            r_total     <= '0;
            r_epoch     <= TAG_W'(1);
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_modulus <= i_cfg.modulus;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (accept && i_item.first) begin
                r_total    <= '0;
                r_epoch    <= (r_epoch == '1) ? TAG_W'(1) : r_epoch + 1'b1;
                r_clr_item <= (r_epoch == '1);
            end
            if (r_state == ST_UPDATE) begin
                r_total   <= total_next;
                r_residue <= r_res;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_res <= div_rem[AW-1:0];
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_total <= r_total;
            r_out_res   <= RES_OUT_W'(r_res);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.total_runs     = r_out_total;
    assign o_result.prefix_residue = r_out_res;

`ifndef SYNTHESIS
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |=> r_total >= $past(r_total))
        else $error("running total decreased on a histogram update");

    a_update_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && r_state == ST_UPDATE |-> ram_wdata.tag == r_epoch && r_epoch != '0)
        else $error("histogram update written with a stale or cleared epoch");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_CLEAR |-> r_epoch != '0)
        else $error("epoch matches the cleared tag outside the clearing pass");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_DIV || r_state == ST_CLEAR)
        else $error("accepted item did not start the remainder unit or clearing pass");
`endif

endmodule
